// ----- design/rsmm_pkg.sv -----
// Shared types and constants for the row-sorted matrix median block.
package rsmm_pkg;

  localparam int DATA_W = 32;
  localparam int CFG_W  = 6;
  // Biased value: sign bit flipped, one extra bit so low can pass the top.
  localparam int VAL_W  = DATA_W + 1;
  localparam logic [DATA_W-1:0] SIGN_FLIP = 32'h8000_0000;

  typedef enum logic {
    REG_ROW_COUNT = 1'b0,
    REG_COL_COUNT = 1'b1
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_RNG_FIRST,
    ST_RNG_LAST,
    ST_RNG_NEXT,
    ST_MID,
    ST_PROBE,
    ST_CMP,
    ST_DECIDE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load_wr;
    logic rng_init;
    logic rng_rd_first;
    logic rng_rd_last;
    logic rng_first;
    logic rng_last;
    logic mid_start;
    logic probe_rd;
    logic probe_cmp;
    logic row_next;
    logic decide;
  } cmd_t;

  typedef struct packed {
    logic load_last;
    logic row_last;
    logic search_open;
    logic probe_open;
    logic count_le_req;
    logic mid_zero;
  } status_t;

endpackage

// ----- design/rsmm_dp.sv -----
// Datapath: matrix memory, value range search and per-row upper-bound search.
module rsmm_dp #(
  parameter int MAX_ROWS = 32,
  parameter int MAX_COLS = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_clear,
  input  logic [rsmm_pkg::CFG_W-1:0]        row_count,
  input  logic [rsmm_pkg::CFG_W-1:0]        col_count,
  input  logic signed [rsmm_pkg::DATA_W-1:0] element_value,
  input  rsmm_pkg::cmd_t                    cmd,
  output rsmm_pkg::status_t                 status,
  output logic signed [rsmm_pkg::DATA_W-1:0] median_value
);

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int RW    = $clog2(MAX_ROWS + 1);
  localparam int CW    = $clog2(MAX_COLS + 1);
  localparam int VW    = rsmm_pkg::VAL_W;

  logic [rsmm_pkg::DATA_W-1:0] mem [DEPTH];
  logic [rsmm_pkg::DATA_W-1:0] mem_q;

  logic [RW-1:0]    rows;
  logic [CW-1:0]    cols;
  logic [CNT_W-1:0] total;
  logic [CNT_W-1:0] req;

  logic [CNT_W-1:0] load_count;
  logic [VW-1:0]    lo;
  logic [VW-1:0]    hi;
  logic [VW-1:0]    mid;
  logic [CNT_W-1:0] count;
  logic [RW-1:0]    row;
  logic [AW-1:0]    base;
  logic [CW-1:0]    rlo;
  logic [CW-1:0]    hip1;   // row search upper bound plus one
  logic [CW-1:0]    ans;

  logic [CW:0]      rsum;
  logic [CW-1:0]    rmid;
  logic [VW:0]      vsum;
  logic [VW-1:0]    mem_b;
  logic [AW-1:0]    base_next;
  logic [AW-1:0]    rd_addr;
  logic             rd_en;

  always_comb begin
    if (row_count == '0) begin
      rows = RW'(1);
    end else if (32'(row_count) > MAX_ROWS) begin
      rows = RW'(MAX_ROWS);
    end else begin
      rows = RW'(row_count);
    end
    if (col_count == '0) begin
      cols = CW'(1);
    end else if (32'(col_count) > MAX_COLS) begin
      cols = CW'(MAX_COLS);
    end else begin
      cols = CW'(col_count);
    end
  end

  assign total = CNT_W'(rows) * CNT_W'(cols);
  assign req   = total >> 1;

  assign rsum      = {1'b0, rlo} + {1'b0, hip1} - (CW+1)'(1);
  assign rmid      = rsum[CW:1];
  assign vsum      = {1'b0, lo} + {1'b0, hi};
  assign mem_b     = {1'b0, mem_q ^ rsmm_pkg::SIGN_FLIP};
  assign base_next = AW'((AW+1)'(base) + (AW+1)'(cols));

  always_comb begin
    rd_en   = cmd.rng_rd_first | cmd.rng_rd_last | cmd.probe_rd;
    rd_addr = base;
    if (cmd.rng_rd_last) begin
      rd_addr = AW'((AW+1)'(base) + (AW+1)'(cols) - (AW+1)'(1));
    end else if (cmd.probe_rd) begin
      rd_addr = AW'((AW+1)'(base) + (AW+1)'(rmid));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_wr) begin
      mem[load_count[AW-1:0]] <= element_value;
    end
    if (rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      load_count <= '0;
    end else if (cfg_clear) begin
      load_count <= '0;
    end else if (cmd.load_wr) begin
      load_count <= status.load_last ? '0 : load_count + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rng_init) begin
      lo   <= {1'b0, {rsmm_pkg::DATA_W{1'b1}}};
      hi   <= '0;
      row  <= '0;
      base <= '0;
    end
    if (cmd.rng_first && (mem_b < lo)) begin
      lo <= mem_b;
    end
    if (cmd.rng_last) begin
      if (mem_b > hi) begin
        hi <= mem_b;
      end
      row  <= row + RW'(1);
      base <= base_next;
    end
    if (cmd.mid_start) begin
      mid   <= vsum[VW:1];
      count <= '0;
      row   <= '0;
      base  <= '0;
      rlo   <= '0;
      hip1  <= cols;
      ans   <= cols;
    end
    if (cmd.probe_cmp) begin
      if (mem_b > mid) begin
        ans  <= rmid;
        hip1 <= rmid;
      end else begin
        rlo <= rmid + CW'(1);
      end
    end
    if (cmd.row_next) begin
      count <= count + CNT_W'(ans);
      row   <= row + RW'(1);
      base  <= base_next;
      rlo   <= '0;
      hip1  <= cols;
      ans   <= cols;
    end
    if (cmd.decide) begin
      if (status.count_le_req) begin
        lo <= mid + VW'(1);
      end else if (!status.mid_zero) begin
        hi <= mid - VW'(1);
      end
    end
  end

  always_comb begin
    status.load_last    = (CNT_W'(load_count + CNT_W'(1)) >= total);
    status.row_last     = (row == rows - RW'(1));
    status.search_open  = (lo <= hi);
    status.probe_open   = (rlo < hip1);
    status.count_le_req = (count <= req);
    status.mid_zero     = (mid == '0);
  end

  assign median_value = lo[rsmm_pkg::DATA_W-1:0] ^ rsmm_pkg::SIGN_FLIP;

endmodule

// ----- design/rsmm_ctrl.sv -----
// Controller: sequences loading, range scan, value search and row searches.
module rsmm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  rsmm_pkg::status_t status,
  output rsmm_pkg::cmd_t    cmd,
  output logic              busy,
  output logic              done
);

  rsmm_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rsmm_pkg::ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    done       = 1'b0;
    unique case (state)
      rsmm_pkg::ST_LOAD: begin
        busy = 1'b0;
        if (start) begin
          cmd.load_wr = 1'b1;
          if (status.load_last) begin
            cmd.rng_init = 1'b1;
            state_next   = rsmm_pkg::ST_RNG_FIRST;
          end
        end
      end
      rsmm_pkg::ST_RNG_FIRST: begin
        cmd.rng_rd_first = 1'b1;
        state_next       = rsmm_pkg::ST_RNG_LAST;
      end
      rsmm_pkg::ST_RNG_LAST: begin
        cmd.rng_first   = 1'b1;
        cmd.rng_rd_last = 1'b1;
        state_next      = rsmm_pkg::ST_RNG_NEXT;
      end
      rsmm_pkg::ST_RNG_NEXT: begin
        cmd.rng_last = 1'b1;
        state_next   = status.row_last ? rsmm_pkg::ST_MID : rsmm_pkg::ST_RNG_FIRST;
      end
      rsmm_pkg::ST_MID: begin
        if (status.search_open) begin
          cmd.mid_start = 1'b1;
          state_next    = rsmm_pkg::ST_PROBE;
        end else begin
          state_next = rsmm_pkg::ST_DONE;
        end
      end
      rsmm_pkg::ST_PROBE: begin
        if (status.probe_open) begin
          cmd.probe_rd = 1'b1;
          state_next   = rsmm_pkg::ST_CMP;
        end else begin
          cmd.row_next = 1'b1;
          if (status.row_last) begin
            state_next = rsmm_pkg::ST_DECIDE;
          end
        end
      end
      rsmm_pkg::ST_CMP: begin
        cmd.probe_cmp = 1'b1;
        state_next    = rsmm_pkg::ST_PROBE;
      end
      rsmm_pkg::ST_DECIDE: begin
        cmd.decide = 1'b1;
        // count above half with a zero midpoint ends the search at once
        if (!status.count_le_req && status.mid_zero) begin
          state_next = rsmm_pkg::ST_DONE;
        end else begin
          state_next = rsmm_pkg::ST_MID;
        end
      end
      rsmm_pkg::ST_DONE: begin
        done       = 1'b1;
        state_next = rsmm_pkg::ST_LOAD;
      end
      default: begin
        state_next = rsmm_pkg::ST_LOAD;
      end
    endcase
  end

endmodule

// ----- design/row_sorted_matrix_median.sv -----
// Top level of the row-sorted matrix median block: config registers and wiring.
//
//  channel   direction  handshake                 payload
//  request   in         start & !busy             element_value
//  result    out        done (one cycle)          median_value
//  config    in         psel & penable & pwrite   paddr, pwdata (prdata on reads)
//
// Loading takes one element per cycle; the request that carries the last
// element starts the search and holds busy high until done.
// Search: a range scan (RNG_FIRST, RNG_LAST, RNG_NEXT for each row), then per
// value step a binary search in every row, up to 33 steps; every probe is
// one read of the single read port. done marks median_value for one cycle.
// rst clears control state; matrix contents stay undefined until loaded.
module row_sorted_matrix_median #(
  parameter int MAX_ROWS = 32,
  parameter int MAX_COLS = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [rsmm_pkg::DATA_W-1:0] element_value,
  output logic                               done,
  output logic signed [rsmm_pkg::DATA_W-1:0] median_value,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [2:0]                         paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  logic [rsmm_pkg::CFG_W-1:0] row_count;
  logic [rsmm_pkg::CFG_W-1:0] col_count;
  logic                       cfg_wr;
  rsmm_pkg::reg_idx_t         reg_idx;
  rsmm_pkg::cmd_t             cmd;
  rsmm_pkg::status_t          status;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign reg_idx = rsmm_pkg::reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= rsmm_pkg::CFG_W'(1);
      col_count <= rsmm_pkg::CFG_W'(1);
    end else if (cfg_wr) begin
      unique case (reg_idx)
        rsmm_pkg::REG_ROW_COUNT: row_count <= pwdata[rsmm_pkg::CFG_W-1:0];
        rsmm_pkg::REG_COL_COUNT: col_count <= pwdata[rsmm_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      rsmm_pkg::REG_ROW_COUNT: prdata = 32'(row_count);
      rsmm_pkg::REG_COL_COUNT: prdata = 32'(col_count);
      default:                 prdata = '0;
    endcase
  end

  rsmm_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  rsmm_dp #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_clear     (cfg_wr),
    .row_count     (row_count),
    .col_count     (col_count),
    .element_value (element_value),
    .cmd           (cmd),
    .status        (status),
    .median_value  (median_value)
  );

  // a result only comes out of a running search
  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("done without busy");

  // after a result the block is ready for the next request
  a_done_release: assert property (@(posedge clk) disable iff (rst) done |=> !busy)
    else $error("busy held after done");

  // the search starts only from an accepted request
  a_busy_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a request");

endmodule
